// ===== src/crng_pkg.sv =====
// shared types and constants of the combined shuffled congruential generator
`default_nettype none

package crng_pkg;

  // generator word and product widths
  localparam int GEN_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = GEN_W + MUL_W;
  localparam int RED_W  = GEN_W + 1;

  // first generator: modulus 2^31 - 85
  localparam logic [RED_W-1:0] MOD1    = 32'd2147483563;
  localparam logic [MUL_W-1:0] MUL1    = 16'd40014;
  localparam logic [RED_W-1:0] FOLD1_C = 32'd85;

  // second generator: modulus 2^31 - 249
  localparam logic [RED_W-1:0] MOD2    = 32'd2147483399;
  localparam logic [MUL_W-1:0] MUL2    = 16'd40692;
  localparam logic [RED_W-1:0] FOLD2_C = 32'd249;

  // output fold value, one below the first modulus
  localparam logic [RED_W-1:0] FOLD_TOP = 32'd2147483562;

  // second generator value after reset
  localparam logic [GEN_W-1:0] SECOND_RESET = 31'd123456789;

  // configuration space
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SEED = 2'd0;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_LOAD,
    ST_IMUL,
    ST_IFOLD,
    ST_IRED,
    ST_MUL,
    ST_FOLD,
    ST_RED,
    ST_OUT
  } crng_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic init_load;
    logic mul_en;
    logic fold_en;
    logic upd_first;
    logic upd_second;
    logic init_wr;
    logic rd_en;
    logic out_ld;
  } crng_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } crng_sts_t;

endpackage

`default_nettype wire

// ===== src/combined_lcg_shuffle_rng.sv =====
// top level: combined shuffled congruential generator with register port
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_stall   in_reseed (1 bit)
//   out      result     out_valid/out_stall out_sample (31 bits)
//   cfg      register   psel/penable/pready paddr, pwdata, prdata (seed)
//
// a plain draw is accepted when idle and runs these steps: multiply, fold,
// reduce with table read, then combine into the output register; a new
// request is taken only once the sequencer is back in idle. initialisation
// (first draw, after a seed write, or reseed set) adds a load step and a
// warm-up loop of the first generator that repeats until its counter runs out.
// reset is synchronous, active low; a stalled result holds the last step.
`default_nettype none

module combined_lcg_shuffle_rng
  import crng_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              in_reseed,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [GEN_W-1:0]  out_sample,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  crng_cmd_t        cmd;
  crng_sts_t        sts;
  logic [GEN_W-1:0] seed_r;
  logic             seed_wr;

  // register port write decode
  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && pready && (paddr == REG_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (seed_wr) begin
      seed_r <= pwdata[GEN_W-1:0];
    end
  end

  // read back
  always_comb begin
    unique case (paddr)
      REG_SEED: prdata = {1'b0, seed_r};
      default:  prdata = '0;
    endcase
  end

  crng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_reseed (in_reseed),
    .seed_wr   (seed_wr),
    .sts       (sts),
    .cmd       (cmd)
  );

  crng_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .seed       (seed_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

endmodule

`default_nettype wire

// ===== src/crng_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module crng_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/crng_dp.sv =====
// datapath: both generators, slot selection, shuffle table and output register
`default_nettype none

module crng_dp
  import crng_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire crng_cmd_t        cmd,
  output      crng_sts_t        sts,
  input  wire logic [GEN_W-1:0] seed,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [GEN_W-1:0] out_sample
);

  // slot divisor and its reciprocal, worked out at elaboration
  localparam longint unsigned SLOT_DIV =
      64'd1 + longint'(FOLD_TOP) / longint'(TABLE_DEPTH);
  localparam longint unsigned RECIP    = (64'd1 << GEN_W) / SLOT_DIV;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int Q_W     = SLOT_W + 1;
  localparam int THR_W   = Q_W + GEN_W;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 8);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(TABLE_DEPTH + 7);

  logic [GEN_W-1:0]  first_gen_r, second_gen_r, last_out_r;
  logic [PROD_W-1:0] prod1_r, prod2_r;
  logic [RED_W-1:0]  fold1_r, fold2_r;
  logic [SLOT_W-1:0] qest_r, slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [GEN_W-1:0]  out_sample_r;

  logic [GEN_W-1:0]  seed_eff;
  logic [PROD_W-1:0] prod1_nxt, prod2_nxt;
  logic [RED_W-1:0]  fold1_nxt, fold2_nxt;
  logic [RED_W-1:0]  red1_full, red2_full;
  logic [GEN_W-1:0]  red1, red2;
  logic [GEN_W+RECIP_W-1:0] qprod;
  logic [SLOT_W-1:0] qest_nxt;
  logic [Q_W-1:0]    qp1, qsel, slot_full;
  logic [THR_W-1:0]  thr;
  logic [SLOT_W-1:0] slot_nxt;
  logic [GEN_W-1:0]  entry;
  logic [RED_W-1:0]  y_full;
  logic [GEN_W-1:0]  y;
  logic              init_in_table;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [GEN_W-1:0]  ram_wdata;
  logic              out_free;

  assign seed_eff = (seed == '0) ? GEN_W'(1) : seed;

  // multiply stage of both generators
  assign prod1_nxt = PROD_W'(first_gen_r) * PROD_W'(MUL1);
  assign prod2_nxt = PROD_W'(second_gen_r) * PROD_W'(MUL2);

  // slot estimate by reciprocal multiply, one low at most
  assign qprod    = (GEN_W+RECIP_W)'(last_out_r) * (GEN_W+RECIP_W)'(RECIP);
  assign qest_nxt = SLOT_W'(qprod >> GEN_W);

  // fold the high part back in: 2^31 is congruent to the modulus offset
  assign fold1_nxt = RED_W'(prod1_r[PROD_W-1:GEN_W]) * FOLD1_C
                   + RED_W'(prod1_r[GEN_W-1:0]);
  assign fold2_nxt = RED_W'(prod2_r[PROD_W-1:GEN_W]) * FOLD2_C
                   + RED_W'(prod2_r[GEN_W-1:0]);

  // slot correction and clamp
  assign qp1       = Q_W'(qest_r) + Q_W'(1);
  assign thr       = THR_W'(qp1) * THR_W'(SLOT_DIV);
  assign qsel      = (THR_W'(last_out_r) >= thr) ? qp1 : Q_W'(qest_r);
  assign slot_full = (qsel >= Q_W'(TABLE_DEPTH)) ? Q_W'(TABLE_DEPTH - 1) : qsel;
  assign slot_nxt  = slot_full[SLOT_W-1:0];

  // final conditional subtract, the folded value is below twice the modulus
  assign red1_full = (fold1_r >= MOD1) ? fold1_r - MOD1 : fold1_r;
  assign red2_full = (fold2_r >= MOD2) ? fold2_r - MOD2 : fold2_r;
  assign red1      = red1_full[GEN_W-1:0];
  assign red2      = red2_full[GEN_W-1:0];

  // combine table entry with second generator
  assign y_full = (entry > second_gen_r) ? RED_W'(entry) - RED_W'(second_gen_r)
                                         : FOLD_TOP - (RED_W'(second_gen_r) - RED_W'(entry));
  assign y      = y_full[GEN_W-1:0];

  // table write port: warm-up fill or refill after a draw
  assign init_in_table = (cnt_r < CNT_W'(TABLE_DEPTH));
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = first_gen_r;
    if (cmd.init_wr) begin
      ram_we    = init_in_table;
      ram_waddr = cnt_r[SLOT_W-1:0];
      ram_wdata = red1;
    end else if (cmd.out_ld) begin
      ram_we    = 1'b1;
    end
  end

  crng_ram #(
    .WIDTH (GEN_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.rd_en),
    .raddr   (slot_r),
    .rd_data (entry)
  );

  // pipeline registers of the multiply-reduce loop
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod1_r <= prod1_nxt;
      prod2_r <= prod2_nxt;
      qest_r  <= qest_nxt;
    end
    if (cmd.fold_en) begin
      fold1_r <= fold1_nxt;
      fold2_r <= fold2_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // generator state, warm-up counter and last output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gen_r  <= '0;
      second_gen_r <= SECOND_RESET;
      last_out_r   <= '0;
      cnt_r        <= '0;
    end else begin
      if (cmd.init_load) begin
        first_gen_r  <= seed_eff;
        second_gen_r <= seed_eff;
        cnt_r        <= CNT_INIT;
      end else begin
        if (cmd.upd_first) begin
          first_gen_r <= red1;
        end
        if (cmd.upd_second) begin
          second_gen_r <= red2;
        end
      end
      if (cmd.init_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          last_out_r <= red1;
        end
      end
      if (cmd.out_ld) begin
        last_out_r <= y;
      end
    end
  end

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_sample_r <= y;
    end
  end

  assign sts.cnt_last = (cnt_r == '0);
  assign sts.out_free = out_free;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;

`ifndef SYNTHESIS
  // a loaded result is valid and never zero
  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> (out_valid_r && (out_sample_r != '0)))
    else $error("loaded sample is zero or not valid");

  // the selected slot always lies inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold_en |=> (Q_W'(slot_r) < Q_W'(TABLE_DEPTH)))
    else $error("slot outside the table");

  // warm-up counter starts at the full step count
  a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_load |=> (cnt_r == CNT_INIT))
    else $error("warm-up counter not loaded");
`endif

endmodule

`default_nettype wire

// ===== src/crng_ctrl.sv =====
// controller: sequences warm-up and draws, tracks pending reinitialisation
`default_nettype none

module crng_ctrl
  import crng_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire logic      in_reseed,
  input  wire logic      seed_wr,
  input  wire crng_sts_t sts,
  output      crng_cmd_t cmd
);

  crng_state_t state_r, state_nxt;
  logic        needs_init_r, needs_init_nxt;
  logic        accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_reseed || needs_init_r) ? ST_INIT_LOAD : ST_MUL;
        end
      end
      ST_INIT_LOAD: state_nxt = ST_IMUL;
      ST_IMUL:      state_nxt = ST_IFOLD;
      ST_IFOLD:     state_nxt = ST_IRED;
      ST_IRED:      state_nxt = sts.cnt_last ? ST_MUL : ST_IMUL;
      ST_MUL:       state_nxt = ST_FOLD;
      ST_FOLD:      state_nxt = ST_RED;
      ST_RED:       state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd = '0;
      ST_INIT_LOAD: cmd.init_load = 1'b1;
      ST_IMUL:      cmd.mul_en = 1'b1;
      ST_IFOLD:     cmd.fold_en = 1'b1;
      ST_IRED: begin
        cmd.upd_first = 1'b1;
        cmd.init_wr   = 1'b1;
      end
      ST_MUL:       cmd.mul_en = 1'b1;
      ST_FOLD:      cmd.fold_en = 1'b1;
      ST_RED: begin
        cmd.upd_first  = 1'b1;
        cmd.upd_second = 1'b1;
        cmd.rd_en      = 1'b1;
      end
      ST_OUT:       cmd.out_ld = sts.out_free;
      default:      cmd = '0;
    endcase
  end

  // pending reinitialisation, a seed write wins over the clear
  always_comb begin
    needs_init_nxt = needs_init_r;
    if (state_r == ST_INIT_LOAD) begin
      needs_init_nxt = 1'b0;
    end
    if (seed_wr) begin
      needs_init_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      needs_init_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      needs_init_r <= needs_init_nxt;
    end
  end

`ifndef SYNTHESIS
  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer idle");

  // a seed write always leaves a reinitialisation pending
  a_seed_pending: assert property (@(posedge clk) disable iff (!rst_n)
    seed_wr |=> needs_init_r)
    else $error("seed write lost");

  // warm-up keeps looping until the counter runs out
  a_warmup_loop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IRED) && !sts.cnt_last) |=> (state_r == ST_IMUL))
    else $error("warm-up left early");
`endif

endmodule

`default_nettype wire
